// File: hw/rtl/affine_rect_bounding_box_core_macros.svh
// Assertion macros for the affine bounding box core.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef AFFINE_RECT_BOUNDING_BOX_CORE_MACROS_SVH
`define AFFINE_RECT_BOUNDING_BOX_CORE_MACROS_SVH

// Checked only out of reset.
`define ARBB_ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ARBB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/arbb_pkg.sv
// Shared widths, constants and types of the affine bounding box core.
// No dependencies.
package arbb_pkg;

  localparam int COORD_BITS     = 24;
  localparam int COEF_BITS      = 16;
  localparam int COEF_FRAC_BITS = 12;

  localparam int SIZE_BITS = COORD_BITS - 1;
  // right = left + width needs one more bit
  localparam int EXT_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS = EXT_BITS + COEF_BITS;
  localparam int SHP_BITS  = PROD_BITS - COEF_FRAC_BITS;
  // two shifted products plus the offset
  localparam int SUM_BITS  = SHP_BITS + 2;
  localparam int DIFF_BITS = SUM_BITS + 1;

  localparam int COORD_MAX = (2 ** (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN = -COORD_MAX - 1;
  localparam int COEF_ONE  = 2 ** COEF_FRAC_BITS;

  // pipeline stages
  localparam int NSTG  = 5;
  localparam int S_IN  = 0;
  localparam int S_MUL = 1;
  localparam int S_CMP = 2;
  localparam int S_SUM = 3;
  localparam int S_OUT = 4;

  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COEF_A   = 3'd0,
    REG_COEF_B   = 3'd1,
    REG_COEF_C   = 3'd2,
    REG_COEF_D   = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5
  } reg_idx_t;

  // stage load enables handed to the per-axis datapath
  typedef struct packed {
    logic mul;
    logic cmp;
    logic sum;
  } arbb_adv_t;

endpackage

// File: hw/rtl/affine_rect_bounding_box_core.sv
// Affine bounding box core: maps a rectangle through a 2D affine transform
// and returns the axis-aligned box of the result. Uses arbb_pkg, arbb_axis.
//
// Five-stage pipeline: input register, multiply, min/max, sum, saturate and
// output register. One rectangle is accepted per cycle unless stalled, and
// its box passes the later stage registers to out_valid; the eight 25x16
// multipliers (four per axis) sit in one stage. Each stage holds its request
// only while the stage after it is full and stalled, so bubbles close up
// under back-pressure. The transform registers are read directly by the
// datapath and should be written only with the pipeline empty.
module affine_rect_bounding_box_core (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [arbb_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [arbb_pkg::COORD_BITS-1:0]         cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [arbb_pkg::COORD_BITS-1:0]  in_origin_x,
  input  logic signed [arbb_pkg::COORD_BITS-1:0]  in_origin_y,
  input  logic [arbb_pkg::SIZE_BITS-1:0]          in_size_w,
  input  logic [arbb_pkg::SIZE_BITS-1:0]          in_size_h,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [arbb_pkg::COORD_BITS-1:0]  out_box_x,
  output logic signed [arbb_pkg::COORD_BITS-1:0]  out_box_y,
  output logic [arbb_pkg::SIZE_BITS-1:0]          out_box_w,
  output logic [arbb_pkg::SIZE_BITS-1:0]          out_box_h,
  output logic                                    out_overflow
);

  // transform registers
  logic signed [arbb_pkg::COEF_BITS-1:0]  coef_a_r, coef_b_r, coef_c_r, coef_d_r;
  logic signed [arbb_pkg::COORD_BITS-1:0] offset_x_r, offset_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r   <= arbb_pkg::COEF_BITS'(arbb_pkg::COEF_ONE);
      coef_b_r   <= '0;
      coef_c_r   <= '0;
      coef_d_r   <= arbb_pkg::COEF_BITS'(arbb_pkg::COEF_ONE);
      offset_x_r <= '0;
      offset_y_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        arbb_pkg::REG_COEF_A:   coef_a_r   <= cfg_data[arbb_pkg::COEF_BITS-1:0];
        arbb_pkg::REG_COEF_B:   coef_b_r   <= cfg_data[arbb_pkg::COEF_BITS-1:0];
        arbb_pkg::REG_COEF_C:   coef_c_r   <= cfg_data[arbb_pkg::COEF_BITS-1:0];
        arbb_pkg::REG_COEF_D:   coef_d_r   <= cfg_data[arbb_pkg::COEF_BITS-1:0];
        arbb_pkg::REG_OFFSET_X: offset_x_r <= cfg_data;
        arbb_pkg::REG_OFFSET_Y: offset_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when it is empty or its content moves on
  logic [arbb_pkg::NSTG-1:0] vld_r, vld_nxt, vld_src;
  logic [arbb_pkg::NSTG:0]   adv;
  arbb_pkg::arbb_adv_t       axis_adv;

  always_comb begin
    adv[arbb_pkg::NSTG] = out_ready;
    for (int k = arbb_pkg::NSTG - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_src = {vld_r[arbb_pkg::NSTG-2:0], in_valid};
    vld_nxt = vld_r;
    for (int k = 0; k < arbb_pkg::NSTG; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready     = adv[arbb_pkg::S_IN];
  assign out_valid    = vld_r[arbb_pkg::S_OUT];
  assign axis_adv.mul = adv[arbb_pkg::S_MUL];
  assign axis_adv.cmp = adv[arbb_pkg::S_CMP];
  assign axis_adv.sum = adv[arbb_pkg::S_SUM];

  // input stage: rectangle edges at full width
  logic signed [arbb_pkg::EXT_BITS-1:0] left_r, right_r, top_r, bottom_r;

  always_ff @(posedge clk) begin
    if (adv[arbb_pkg::S_IN]) begin
      left_r   <= arbb_pkg::EXT_BITS'(in_origin_x);
      top_r    <= arbb_pkg::EXT_BITS'(in_origin_y);
      right_r  <= arbb_pkg::EXT_BITS'(in_origin_x)
                + arbb_pkg::EXT_BITS'(signed'({1'b0, in_size_w}));
      bottom_r <= arbb_pkg::EXT_BITS'(in_origin_y)
                + arbb_pkg::EXT_BITS'(signed'({1'b0, in_size_h}));
    end
  end

  logic signed [arbb_pkg::SUM_BITS-1:0] minx, maxx, miny, maxy;

  arbb_axis u_axis_x (
    .clk    (clk),
    .adv    (axis_adv),
    .p_lo   (left_r),
    .p_hi   (right_r),
    .q_lo   (top_r),
    .q_hi   (bottom_r),
    .coef_p (coef_a_r),
    .coef_q (coef_c_r),
    .offset (offset_x_r),
    .lo_sum (minx),
    .hi_sum (maxx)
  );

  arbb_axis u_axis_y (
    .clk    (clk),
    .adv    (axis_adv),
    .p_lo   (left_r),
    .p_hi   (right_r),
    .q_lo   (top_r),
    .q_hi   (bottom_r),
    .coef_p (coef_b_r),
    .coef_q (coef_d_r),
    .offset (offset_y_r),
    .lo_sum (miny),
    .hi_sum (maxy)
  );

  // saturation
  localparam logic signed [arbb_pkg::SUM_BITS-1:0]  S_MAX =
    arbb_pkg::SUM_BITS'(arbb_pkg::COORD_MAX);
  localparam logic signed [arbb_pkg::SUM_BITS-1:0]  S_MIN =
    arbb_pkg::SUM_BITS'(arbb_pkg::COORD_MIN);
  localparam logic signed [arbb_pkg::DIFF_BITS-1:0] D_MAX =
    arbb_pkg::DIFF_BITS'(arbb_pkg::COORD_MAX);

  logic signed [arbb_pkg::DIFF_BITS-1:0]  dx, dy;
  logic                                   ox_hi, ox_lo, oy_hi, oy_lo, ow, oh;
  logic signed [arbb_pkg::COORD_BITS-1:0] box_x_nxt, box_y_nxt;
  logic [arbb_pkg::SIZE_BITS-1:0]         box_w_nxt, box_h_nxt;

  always_comb begin
    dx    = arbb_pkg::DIFF_BITS'(maxx) - arbb_pkg::DIFF_BITS'(minx);
    dy    = arbb_pkg::DIFF_BITS'(maxy) - arbb_pkg::DIFF_BITS'(miny);
    ox_hi = minx > S_MAX;
    ox_lo = minx < S_MIN;
    oy_hi = miny > S_MAX;
    oy_lo = miny < S_MIN;
    ow    = dx > D_MAX;
    oh    = dy > D_MAX;

    priority if (ox_hi) box_x_nxt = arbb_pkg::COORD_BITS'(arbb_pkg::COORD_MAX);
    else if (ox_lo)     box_x_nxt = arbb_pkg::COORD_BITS'(arbb_pkg::COORD_MIN);
    else                box_x_nxt = minx[arbb_pkg::COORD_BITS-1:0];

    priority if (oy_hi) box_y_nxt = arbb_pkg::COORD_BITS'(arbb_pkg::COORD_MAX);
    else if (oy_lo)     box_y_nxt = arbb_pkg::COORD_BITS'(arbb_pkg::COORD_MIN);
    else                box_y_nxt = miny[arbb_pkg::COORD_BITS-1:0];

    box_w_nxt = ow ? arbb_pkg::SIZE_BITS'(arbb_pkg::COORD_MAX)
                   : dx[arbb_pkg::SIZE_BITS-1:0];
    box_h_nxt = oh ? arbb_pkg::SIZE_BITS'(arbb_pkg::COORD_MAX)
                   : dy[arbb_pkg::SIZE_BITS-1:0];
  end

  logic signed [arbb_pkg::COORD_BITS-1:0] box_x_r, box_y_r;
  logic [arbb_pkg::SIZE_BITS-1:0]         box_w_r, box_h_r;
  logic                                   ovf_r;

  always_ff @(posedge clk) begin
    if (adv[arbb_pkg::S_OUT]) begin
      box_x_r <= box_x_nxt;
      box_y_r <= box_y_nxt;
      box_w_r <= box_w_nxt;
      box_h_r <= box_h_nxt;
      ovf_r   <= ox_hi | ox_lo | oy_hi | oy_lo | ow | oh;
    end
  end

  assign out_box_x    = box_x_r;
  assign out_box_y    = box_y_r;
  assign out_box_w    = box_w_r;
  assign out_box_h    = box_h_r;
  assign out_overflow = ovf_r;

endmodule

// File: hw/rtl/arbb_axis.sv
// One output axis of the affine map: four products, pairwise min/max, sums.
// Uses arbb_pkg; stage enables come from the core's pipeline control.
module arbb_axis (
  input  logic                                   clk,
  input  arbb_pkg::arbb_adv_t                    adv,
  input  logic signed [arbb_pkg::EXT_BITS-1:0]   p_lo,
  input  logic signed [arbb_pkg::EXT_BITS-1:0]   p_hi,
  input  logic signed [arbb_pkg::EXT_BITS-1:0]   q_lo,
  input  logic signed [arbb_pkg::EXT_BITS-1:0]   q_hi,
  input  logic signed [arbb_pkg::COEF_BITS-1:0]  coef_p,
  input  logic signed [arbb_pkg::COEF_BITS-1:0]  coef_q,
  input  logic signed [arbb_pkg::COORD_BITS-1:0] offset,
  output logic signed [arbb_pkg::SUM_BITS-1:0]   lo_sum,
  output logic signed [arbb_pkg::SUM_BITS-1:0]   hi_sum
);

  logic signed [arbb_pkg::PROD_BITS-1:0] m_pl, m_ph, m_ql, m_qh;
  logic signed [arbb_pkg::SHP_BITS-1:0]  pl_r, ph_r, ql_r, qh_r;
  logic signed [arbb_pkg::SHP_BITS-1:0]  pmin_r, pmax_r, qmin_r, qmax_r;
  logic signed [arbb_pkg::SUM_BITS-1:0]  lo_r, hi_r;

  assign m_pl = arbb_pkg::PROD_BITS'(coef_p) * arbb_pkg::PROD_BITS'(p_lo);
  assign m_ph = arbb_pkg::PROD_BITS'(coef_p) * arbb_pkg::PROD_BITS'(p_hi);
  assign m_ql = arbb_pkg::PROD_BITS'(coef_q) * arbb_pkg::PROD_BITS'(q_lo);
  assign m_qh = arbb_pkg::PROD_BITS'(coef_q) * arbb_pkg::PROD_BITS'(q_hi);

  // dropping the fraction bits of a two's complement value is a floor
  always_ff @(posedge clk) begin
    if (adv.mul) begin
      pl_r <= m_pl[arbb_pkg::PROD_BITS-1:arbb_pkg::COEF_FRAC_BITS];
      ph_r <= m_ph[arbb_pkg::PROD_BITS-1:arbb_pkg::COEF_FRAC_BITS];
      ql_r <= m_ql[arbb_pkg::PROD_BITS-1:arbb_pkg::COEF_FRAC_BITS];
      qh_r <= m_qh[arbb_pkg::PROD_BITS-1:arbb_pkg::COEF_FRAC_BITS];
    end
  end

  // the two terms pick their corner independently, so the extremes of the
  // four corner sums are sums of the per-term extremes
  always_ff @(posedge clk) begin
    if (adv.cmp) begin
      pmin_r <= (pl_r < ph_r) ? pl_r : ph_r;
      pmax_r <= (pl_r < ph_r) ? ph_r : pl_r;
      qmin_r <= (ql_r < qh_r) ? ql_r : qh_r;
      qmax_r <= (ql_r < qh_r) ? qh_r : ql_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.sum) begin
      lo_r <= arbb_pkg::SUM_BITS'(pmin_r) + arbb_pkg::SUM_BITS'(qmin_r)
            + arbb_pkg::SUM_BITS'(offset);
      hi_r <= arbb_pkg::SUM_BITS'(pmax_r) + arbb_pkg::SUM_BITS'(qmax_r)
            + arbb_pkg::SUM_BITS'(offset);
    end
  end

  assign lo_sum = lo_r;
  assign hi_sum = hi_r;

endmodule

// File: hw/rtl/arbb_checker.sv
// Port-level checks of the affine bounding box core, bound to the top level.
// Uses arbb_pkg and the core's assertion macros.
`include "affine_rect_bounding_box_core_macros.svh"

module arbb_checker (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    cfg_valid,
  input logic                                    cfg_ready,
  input logic [arbb_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input logic [arbb_pkg::COORD_BITS-1:0]         cfg_data,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic signed [arbb_pkg::COORD_BITS-1:0]  in_origin_x,
  input logic signed [arbb_pkg::COORD_BITS-1:0]  in_origin_y,
  input logic [arbb_pkg::SIZE_BITS-1:0]          in_size_w,
  input logic [arbb_pkg::SIZE_BITS-1:0]          in_size_h,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic signed [arbb_pkg::COORD_BITS-1:0]  out_box_x,
  input logic signed [arbb_pkg::COORD_BITS-1:0]  out_box_y,
  input logic [arbb_pkg::SIZE_BITS-1:0]          out_box_w,
  input logic [arbb_pkg::SIZE_BITS-1:0]          out_box_h,
  input logic                                    out_overflow
);

  // reset empties the pipeline
  `ARBB_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

  // with no result waiting, no stage can be stalled
  `ARBB_ASSERT_ON(a_ready_when_drained, !out_valid |-> in_ready, "input stalled while output empty")

  `ARBB_ASSERT_ON(a_out_hold, out_valid && !out_ready |=> out_valid, "result request dropped")

  `ARBB_ASSERT_ON(a_out_stable, out_valid && !out_ready |=> $stable(out_box_x) && $stable(out_box_y) && $stable(out_box_w) && $stable(out_box_h) && $stable(out_overflow), "stalled result changed")

endmodule

bind affine_rect_bounding_box_core arbb_checker u_arbb_checker (.*);

// File: test/affine_box_checker.sv
// Checker for the affine bounding box core: follows register writes, predicts
// the box of every accepted rectangle request and compares the returned boxes.
// Depends on arbb_pkg.
module affine_box_checker (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_valid,
  input  logic                                    cfg_ready,
  input  logic [arbb_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [arbb_pkg::COORD_BITS-1:0]         cfg_data,
  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic signed [arbb_pkg::COORD_BITS-1:0]  in_origin_x,
  input  logic signed [arbb_pkg::COORD_BITS-1:0]  in_origin_y,
  input  logic [arbb_pkg::SIZE_BITS-1:0]          in_size_w,
  input  logic [arbb_pkg::SIZE_BITS-1:0]          in_size_h,
  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic signed [arbb_pkg::COORD_BITS-1:0]  out_box_x,
  input  logic signed [arbb_pkg::COORD_BITS-1:0]  out_box_y,
  input  logic [arbb_pkg::SIZE_BITS-1:0]          out_box_w,
  input  logic [arbb_pkg::SIZE_BITS-1:0]          out_box_h,
  input  logic                                    out_overflow,
  output int                                      mismatches,
  output int                                      boxes_due
);

  typedef struct packed {
    logic [arbb_pkg::COORD_BITS-1:0] x;
    logic [arbb_pkg::COORD_BITS-1:0] y;
    logic [arbb_pkg::SIZE_BITS-1:0]  w;
    logic [arbb_pkg::SIZE_BITS-1:0]  h;
    logic                            ovf;
  } box_t;

  box_t   boxes_q[$];
  int     fail_total = 0;
  int     due_count = 0;

  // transform registers, kept sign-extended
  longint coef_a = arbb_pkg::COEF_ONE;
  longint coef_b = 0;
  longint coef_c = 0;
  longint coef_d = arbb_pkg::COEF_ONE;
  longint shift_x = 0;
  longint shift_y = 0;

  assign mismatches = fail_total;
  assign boxes_due  = due_count;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    fail_total++;
  endtask

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi,
                                      inout bit hit);
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    return v;
  endfunction

  // >>> on signed longint is a floor shift; sums stay exact until the clamp
  function automatic box_t predict_box(input longint left, input longint top,
                                       input longint wid, input longint hgt);
    longint cx[4];
    longint cy[4];
    longint xs[4];
    longint ys[4];
    longint min_x, max_x, min_y, max_y;
    bit     hit;
    box_t   b;
    cx[0] = left;       cy[0] = top;
    cx[1] = left + wid; cy[1] = top;
    cx[2] = left;       cy[2] = top + hgt;
    cx[3] = left + wid; cy[3] = top + hgt;
    hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      xs[i] = ((coef_a * cx[i]) >>> arbb_pkg::COEF_FRAC_BITS)
              + ((coef_c * cy[i]) >>> arbb_pkg::COEF_FRAC_BITS) + shift_x;
      ys[i] = ((coef_b * cx[i]) >>> arbb_pkg::COEF_FRAC_BITS)
              + ((coef_d * cy[i]) >>> arbb_pkg::COEF_FRAC_BITS) + shift_y;
    end
    min_x = xs[0]; max_x = xs[0];
    min_y = ys[0]; max_y = ys[0];
    for (int i = 1; i < 4; i++) begin
      if (xs[i] < min_x) min_x = xs[i];
      if (xs[i] > max_x) max_x = xs[i];
      if (ys[i] < min_y) min_y = ys[i];
      if (ys[i] > max_y) max_y = ys[i];
    end
    b.x   = arbb_pkg::COORD_BITS'(clamp_to(min_x, arbb_pkg::COORD_MIN,
                                           arbb_pkg::COORD_MAX, hit));
    b.y   = arbb_pkg::COORD_BITS'(clamp_to(min_y, arbb_pkg::COORD_MIN,
                                           arbb_pkg::COORD_MAX, hit));
    b.w   = arbb_pkg::SIZE_BITS'(clamp_to(max_x - min_x, 0, arbb_pkg::COORD_MAX, hit));
    b.h   = arbb_pkg::SIZE_BITS'(clamp_to(max_y - min_y, 0, arbb_pkg::COORD_MAX, hit));
    b.ovf = hit;
    return b;
  endfunction

  always @(posedge clk) begin
    box_t want;
    if (!rst_n) begin
      coef_a  = arbb_pkg::COEF_ONE;
      coef_b  = 0;
      coef_c  = 0;
      coef_d  = arbb_pkg::COEF_ONE;
      shift_x = 0;
      shift_y = 0;
      boxes_q.delete();
    end else begin
      // compare before queuing: a box can never leave in its own accept cycle
      if (out_valid && out_ready) begin
        if (boxes_q.size() == 0) begin
          report_mismatch($sformatf("box with no request pending: x=%0d y=%0d w=%0d h=%0d",
                                    out_box_x, out_box_y, out_box_w, out_box_h));
        end else begin
          want = boxes_q.pop_front();
          if (out_box_x !== want.x)
            report_mismatch($sformatf("box_x got %0d want %0d", out_box_x, $signed(want.x)));
          if (out_box_y !== want.y)
            report_mismatch($sformatf("box_y got %0d want %0d", out_box_y, $signed(want.y)));
          if (out_box_w !== want.w)
            report_mismatch($sformatf("box_w got %0d want %0d", out_box_w, want.w));
          if (out_box_h !== want.h)
            report_mismatch($sformatf("box_h got %0d want %0d", out_box_h, want.h));
          if (out_overflow !== want.ovf)
            report_mismatch($sformatf("overflow got %b want %b", out_overflow, want.ovf));
        end
      end
      if (in_valid && in_ready)
        boxes_q.push_back(predict_box(longint'(in_origin_x), longint'(in_origin_y),
                                      longint'(in_size_w), longint'(in_size_h)));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          arbb_pkg::REG_COEF_A:
            coef_a  = longint'($signed(cfg_data[arbb_pkg::COEF_BITS-1:0]));
          arbb_pkg::REG_COEF_B:
            coef_b  = longint'($signed(cfg_data[arbb_pkg::COEF_BITS-1:0]));
          arbb_pkg::REG_COEF_C:
            coef_c  = longint'($signed(cfg_data[arbb_pkg::COEF_BITS-1:0]));
          arbb_pkg::REG_COEF_D:
            coef_d  = longint'($signed(cfg_data[arbb_pkg::COEF_BITS-1:0]));
          arbb_pkg::REG_OFFSET_X: shift_x = longint'($signed(cfg_data));
          arbb_pkg::REG_OFFSET_Y: shift_y = longint'($signed(cfg_data));
          default: ;
        endcase
      end
    end
    due_count = boxes_q.size();
  end

endmodule

// File: test/testbench.sv
// Top of the affine bounding box testbench: clock, reset, rectangle and
// register stimulus with random idling, and the verdict.
// Depends on arbb_pkg, affine_rect_bounding_box_core and affine_box_checker.
module testbench;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int RAND_PHASES     = 9;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOLD_CYCLES     = 80;
  localparam int DRAIN_CYCLES    = 4 * arbb_pkg::NSTG;

  localparam logic [arbb_pkg::CFG_IDX_BITS-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [arbb_pkg::CFG_IDX_BITS-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [arbb_pkg::SIZE_BITS-1:0]    SIZE_MAX     = '1;
  localparam logic [arbb_pkg::COORD_BITS-1:0]   C_MAX =
    arbb_pkg::COORD_BITS'(arbb_pkg::COORD_MAX);
  localparam logic [arbb_pkg::COORD_BITS-1:0]   C_MIN =
    arbb_pkg::COORD_BITS'(arbb_pkg::COORD_MIN);
  localparam logic [arbb_pkg::COEF_BITS-1:0]    COEF_UNIT =
    arbb_pkg::COEF_BITS'(arbb_pkg::COEF_ONE);
  localparam logic [arbb_pkg::COEF_BITS-1:0]    COEF_NEG =
    arbb_pkg::COEF_BITS'(-arbb_pkg::COEF_ONE);
  localparam logic [arbb_pkg::COEF_BITS-1:0]    COEF_DOUBLE =
    arbb_pkg::COEF_BITS'(2 * arbb_pkg::COEF_ONE);

  logic                                   clk = 1'b0;
  logic                                   rst_n;
  logic                                   cfg_valid;
  logic                                   cfg_ready;
  logic [arbb_pkg::CFG_IDX_BITS-1:0]      cfg_index;
  logic [arbb_pkg::COORD_BITS-1:0]        cfg_data;
  logic                                   in_valid;
  logic                                   in_ready;
  logic signed [arbb_pkg::COORD_BITS-1:0] in_origin_x;
  logic signed [arbb_pkg::COORD_BITS-1:0] in_origin_y;
  logic [arbb_pkg::SIZE_BITS-1:0]         in_size_w;
  logic [arbb_pkg::SIZE_BITS-1:0]         in_size_h;
  logic                                   out_valid;
  logic                                   out_ready;
  logic signed [arbb_pkg::COORD_BITS-1:0] out_box_x;
  logic signed [arbb_pkg::COORD_BITS-1:0] out_box_y;
  logic [arbb_pkg::SIZE_BITS-1:0]         out_box_w;
  logic [arbb_pkg::SIZE_BITS-1:0]         out_box_h;
  logic                                   out_overflow;

  int mismatches;
  int boxes_due;
  int cycle_count = 0;
  int send_idle = 38;
  int recv_idle = 83;
  int hold_asks = 0;
  int hold_seen = 0;

  affine_rect_bounding_box_core u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_origin_x  (in_origin_x),
    .in_origin_y  (in_origin_y),
    .in_size_w    (in_size_w),
    .in_size_h    (in_size_h),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_box_x    (out_box_x),
    .out_box_y    (out_box_y),
    .out_box_w    (out_box_w),
    .out_box_h    (out_box_h),
    .out_overflow (out_overflow)
  );

  affine_box_checker u_box_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_origin_x  (in_origin_x),
    .in_origin_y  (in_origin_y),
    .in_size_w    (in_size_w),
    .in_size_h    (in_size_h),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_box_x    (out_box_x),
    .out_box_y    (out_box_y),
    .out_box_w    (out_box_w),
    .out_box_h    (out_box_h),
    .out_overflow (out_overflow),
    .mismatches   (mismatches),
    .boxes_due    (boxes_due)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side: random ready, plus a long hold-off whenever one is asked for
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic cfg_write(input logic [arbb_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [arbb_pkg::COORD_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // upper bits of a coefficient write carry junk, the block keeps the low 16
  task automatic load_map(input logic [arbb_pkg::COEF_BITS-1:0] a,
                          input logic [arbb_pkg::COEF_BITS-1:0] b,
                          input logic [arbb_pkg::COEF_BITS-1:0] c,
                          input logic [arbb_pkg::COEF_BITS-1:0] d,
                          input logic [arbb_pkg::COORD_BITS-1:0] ox,
                          input logic [arbb_pkg::COORD_BITS-1:0] oy);
    cfg_write(arbb_pkg::REG_COEF_A,
              arbb_pkg::COORD_BITS'(($urandom << arbb_pkg::COEF_BITS) | a));
    cfg_write(arbb_pkg::REG_COEF_B,
              arbb_pkg::COORD_BITS'(($urandom << arbb_pkg::COEF_BITS) | b));
    cfg_write(arbb_pkg::REG_COEF_C,
              arbb_pkg::COORD_BITS'(($urandom << arbb_pkg::COEF_BITS) | c));
    cfg_write(arbb_pkg::REG_COEF_D,
              arbb_pkg::COORD_BITS'(($urandom << arbb_pkg::COEF_BITS) | d));
    cfg_write(arbb_pkg::REG_OFFSET_X, ox);
    cfg_write(arbb_pkg::REG_OFFSET_Y, oy);
  endtask

  // valid is left high after acceptance; the next call lowers or reloads it
  task automatic send_rect(input logic [arbb_pkg::COORD_BITS-1:0] ox,
                           input logic [arbb_pkg::COORD_BITS-1:0] oy,
                           input logic [arbb_pkg::SIZE_BITS-1:0] w,
                           input logic [arbb_pkg::SIZE_BITS-1:0] h);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_origin_x <= ox;
    in_origin_y <= oy;
    in_size_w   <= w;
    in_size_h   <= h;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (boxes_due != 0) @(negedge clk);
  endtask

  function automatic logic [arbb_pkg::COORD_BITS-1:0] pick_coord();
    case ($urandom_range(4))
      0:       return arbb_pkg::COORD_BITS'($urandom);
      1:       return arbb_pkg::COORD_BITS'(int'($urandom_range(2048)) - 1024);
      2:       return $urandom_range(1) ? C_MAX : C_MIN;
      default: return arbb_pkg::COORD_BITS'(int'($urandom_range(131072)) - 65536);
    endcase
  endfunction

  function automatic logic [arbb_pkg::SIZE_BITS-1:0] pick_size();
    case ($urandom_range(4))
      0:       return arbb_pkg::SIZE_BITS'($urandom);
      1:       return arbb_pkg::SIZE_BITS'($urandom_range(1024));
      2:       return $urandom_range(1) ? SIZE_MAX : '0;
      default: return arbb_pkg::SIZE_BITS'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [arbb_pkg::COEF_BITS-1:0] pick_coef();
    case ($urandom_range(5))
      0:       return arbb_pkg::COEF_BITS'($urandom);
      1:       return arbb_pkg::COEF_BITS'(arbb_pkg::COEF_ONE
                                           + int'($urandom_range(256)) - 128);
      2:       return COEF_NEG;
      3:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
      4:       return '0;
      default: return arbb_pkg::COEF_BITS'(int'($urandom_range(8192)) - 4096);
    endcase
  endfunction

  initial begin
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_origin_x = '0;
    in_origin_y = '0;
    in_size_w   = '0;
    in_size_h   = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // identity map straight out of reset
    send_rect('0, '0, '0, '0);
    send_rect(C_MAX, C_MAX, SIZE_MAX, SIZE_MAX);
    send_rect(C_MIN, C_MIN, SIZE_MAX, SIZE_MAX);
    send_rect('1, '1, 23'h2aaaaa, 23'h555555);
    send_rect(24'h555555, 24'haaaaaa, 23'd1, 23'd1);

    // most negative gains with extreme offsets: saturating cases
    settle();
    load_map(16'h8000, 16'h8000, 16'h8000, 16'h8000, C_MAX, C_MIN);
    send_rect(C_MAX, C_MIN, SIZE_MAX, '0);
    send_rect(C_MIN, C_MAX, '0, SIZE_MAX);
    send_rect(24'd256, -24'sd256, 23'd512, 23'd512);

    settle();
    load_map(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, C_MIN, C_MAX);
    send_rect(C_MAX, C_MAX, SIZE_MAX, SIZE_MAX);
    send_rect(C_MIN, C_MIN, '0, '0);
    send_rect('1, '1, 23'd1, 23'd1);

    // all-zero gains collapse every box onto the offset
    settle();
    load_map('0, '0, '0, '0, pick_coord(), pick_coord());
    send_rect(pick_coord(), pick_coord(), pick_size(), pick_size());
    send_rect(C_MIN, C_MAX, SIZE_MAX, SIZE_MAX);

    // quarter turn, then junk into the unused register slots
    settle();
    load_map('0, COEF_UNIT, COEF_NEG, '0, '0, '0);
    send_rect(24'd1000, -24'sd3000, 23'd700, 23'd90);
    send_rect(-24'sd5, 24'd77, 23'd0, 23'd12345);
    settle();
    cfg_write(REG_SPARE_LO, arbb_pkg::COORD_BITS'($urandom));
    cfg_write(REG_SPARE_HI, arbb_pkg::COORD_BITS'($urandom));
    send_rect(24'd1000, -24'sd3000, 23'd700, 23'd90);

    // double scale overruns the extent; mirror flips x
    settle();
    load_map(COEF_DOUBLE, '0, '0, COEF_DOUBLE, 24'd100, -24'sd100);
    send_rect('0, '0, SIZE_MAX, 23'd4);
    send_rect(C_MAX, C_MIN, 23'd1, SIZE_MAX);
    settle();
    load_map(COEF_NEG, '0, '0, COEF_UNIT, '0, '0);
    send_rect(C_MIN, 24'd10, 23'd300, 23'd300);
    send_rect(-24'sd1, 24'd0, 23'd1, 23'd1);

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      case (p / 3)
        0: begin
          send_idle = 38;
          recv_idle = 83;
        end
        1: begin
          send_idle = 83;
          recv_idle = 38;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      if ($urandom_range(1))
        cfg_write($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                  arbb_pkg::COORD_BITS'($urandom));
      load_map(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coord(), pick_coord());
      // sender keeps streaming while the result side holds off
      if (p == 6 || p == 7)
        hold_asks++;
      repeat (ITEMS_PER_PHASE)
        send_rect(pick_coord(), pick_coord(), pick_size(), pick_size());
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && boxes_due == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
